/* sv/message_fifo_with_type_removal_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the message queue
// Each macro expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef MESSAGE_FIFO_WITH_TYPE_REMOVAL_UNIT_ASSERT_SVH
`define MESSAGE_FIFO_WITH_TYPE_REMOVAL_UNIT_ASSERT_SVH

// cond must never hold
`define MFQ_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// ante implies cons in the same cycle
`define MFQ_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons in the next cycle
`define MFQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/mfq_pkg.sv */
// ----------------------------------------------------------------------------
// mfq_pkg
// Types, codes and pointer helpers shared by the message queue modules.
// ----------------------------------------------------------------------------
package mfq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [2:0] ACT_PUT    = 3'd0;
    localparam logic [2:0] ACT_GET    = 3'd1;
    localparam logic [2:0] ACT_REMOVE = 3'd2;
    localparam logic [2:0] ACT_FLUSH  = 3'd3;
    localparam logic [2:0] ACT_ABORT  = 3'd4;
    localparam logic [2:0] ACT_START  = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_ABORTED = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [2:0]         action;
        logic [15:0]        msg_type;
        logic signed [31:0] arg_one;
        logic signed [31:0] arg_two;
        logic               wait_if_empty;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               delivered;
        logic [15:0]        out_type;
        logic signed [31:0] out_arg_one;
        logic signed [31:0] out_arg_two;
        logic [4:0]         queued_count;
    } out_item_t;

    typedef struct packed {
        logic [15:0]        msg_type;
        logic signed [31:0] arg_one;
        logic signed [31:0] arg_two;
    } entry_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_RES_STATUS,
        OP_DELIVER,
        OP_ENQUEUE,
        OP_GET_ISSUE,
        OP_GET_TAKE,
        OP_PARK,
        OP_FLUSH,
        OP_ABORT,
        OP_RM_START,
        OP_RM_READ,
        OP_RM_CHECK,
        OP_RM_END
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] res_status;
        logic       clear_abort;
        logic       take_item;
        logic       emit;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] action;
        logic       wait_if_empty;
        logic       aborted;
        logic       waiting;
        logic       empty;
        logic       full;
        logic       rm_done;
        logic       out_free;
    } dp_sts_t;

    // (base + off) mod QUEUE_DEPTH, with base < QUEUE_DEPTH and off <= QUEUE_DEPTH
    function automatic logic [IDX_W-1:0] wrap_add(logic [IDX_W-1:0] base,
                                                  logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(QUEUE_DEPTH))
        begin
            sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

/* sv/message_fifo_with_type_removal_unit.sv */
// ----------------------------------------------------------------------------
// message_fifo_with_type_removal_unit
// Bounded message queue with abort, one parked reader and removal by type.
//
// channel  handshake              payload      role
// cmd      cmd_valid / cmd_stall  cmd_item     request transactions in
// rsp      rsp_valid / rsp_stall  rsp_item     result transactions out
// cfg      cfg_valid / cfg_ready  cfg_data     flush_type register write
//
// One transaction at a time. Put, start, flush, abort and rejected requests
// go from accept through S_EXEC to S_RESP; get with data passes S_GET_READ
// on the way; a parked get returns to idle with no result; remove loops
// S_RM_READ and S_RM_CHECK, one store read and one compare/write per message.
// Reset leaves the queue empty and aborted. A stalled result sits in the
// output register; the next request is taken meanwhile, and its own result
// waits until that register frees up.
// ----------------------------------------------------------------------------
module message_fifo_with_type_removal_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  mfq_pkg::in_item_t  cmd_item,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output mfq_pkg::out_item_t rsp_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data
);

    mfq_pkg::dp_cmd_t dp_cmd;
    mfq_pkg::dp_sts_t dp_sts;

    assign cfg_ready = 1'b1;

    mfq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .sts       (dp_sts),
        .cmd       (dp_cmd)
    );

    mfq_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_item  (cmd_item),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (dp_cmd),
        .sts       (dp_sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

`include "message_fifo_with_type_removal_unit_assert.svh"

    `MFQ_ASSERT_NEVER(a_reader_with_data, dp_sts.waiting && !dp_sts.empty, "reader parked while queue holds data")
    `MFQ_ASSERT_NEXT(a_busy_after_accept, cmd_valid && !cmd_stall, cmd_stall, "accepted transaction did not start work")
    `MFQ_ASSERT_IMPLIES(a_delivery_ok, rsp_valid && rsp_item.delivered, rsp_item.status == mfq_pkg::ST_OK, "delivered message with error status")

endmodule

/* sv/mfq_datapath.sv */
// ----------------------------------------------------------------------------
// mfq_datapath
// Message store, queue pointers, flags, result staging and output register.
// ----------------------------------------------------------------------------
module mfq_datapath
(
    input  logic               clk,
    input  logic               rst_n,
    input  mfq_pkg::in_item_t  cmd_item,
    input  logic               cfg_valid,
    input  logic [15:0]        cfg_data,
    input  mfq_pkg::dp_cmd_t   cmd,
    output mfq_pkg::dp_sts_t   sts,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output mfq_pkg::out_item_t rsp_item
);

    mfq_pkg::entry_t             mem [mfq_pkg::QUEUE_DEPTH];
    mfq_pkg::entry_t             rd_reg;
    mfq_pkg::in_item_t           item_reg;
    mfq_pkg::out_item_t          res_reg;
    mfq_pkg::out_item_t          res_next;
    mfq_pkg::out_item_t          out_reg;
    mfq_pkg::out_item_t          out_next;
    logic                        out_valid_reg;
    logic [15:0]                 flush_type_reg;
    logic [mfq_pkg::IDX_W-1:0]   head_reg;
    logic [mfq_pkg::CNT_W-1:0]   count_reg;
    logic [mfq_pkg::CNT_W-1:0]   rd_cnt_reg;
    logic [mfq_pkg::CNT_W-1:0]   wr_cnt_reg;
    logic                        abort_reg;
    logic                        waiting_reg;

    mfq_pkg::entry_t             offer_msg;
    logic                        wr_en;
    logic [mfq_pkg::IDX_W-1:0]   wr_addr;
    mfq_pkg::entry_t             wr_data;
    logic                        rd_en;
    logic [mfq_pkg::IDX_W-1:0]   rd_addr;
    logic                        rm_match;
    logic                        out_free;

    always_comb
    begin
        if (item_reg.action == mfq_pkg::ACT_START)
        begin
            offer_msg.msg_type = flush_type_reg;
            offer_msg.arg_one  = '0;
            offer_msg.arg_two  = '0;
        end
        else
        begin
            offer_msg.msg_type = item_reg.msg_type;
            offer_msg.arg_one  = item_reg.arg_one;
            offer_msg.arg_two  = item_reg.arg_two;
        end
    end

    assign rm_match = (rd_reg.msg_type == item_reg.msg_type);
    assign out_free = !out_valid_reg || !rsp_stall;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = mfq_pkg::wrap_add(head_reg, count_reg);
        wr_data = offer_msg;
        rd_en   = 1'b0;
        rd_addr = head_reg;
        unique case (cmd.op)
            mfq_pkg::OP_ENQUEUE:
            begin
                wr_en = 1'b1;
            end
            mfq_pkg::OP_GET_ISSUE:
            begin
                rd_en = 1'b1;
            end
            mfq_pkg::OP_RM_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = mfq_pkg::wrap_add(head_reg, rd_cnt_reg);
            end
            mfq_pkg::OP_RM_CHECK:
            begin
                wr_en   = !rm_match;
                wr_addr = mfq_pkg::wrap_add(head_reg, wr_cnt_reg);
                wr_data = rd_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flush_type_reg <= '0;
        end
        else if (cfg_valid)
        begin
            flush_type_reg <= cfg_data;
        end
    end

    always_comb
    begin
        res_next = res_reg;
        if (cmd.op != mfq_pkg::OP_NONE)
        begin
            res_next        = '0;
            res_next.status = cmd.res_status;
            if (cmd.op == mfq_pkg::OP_DELIVER)
            begin
                res_next.delivered   = 1'b1;
                res_next.out_type    = offer_msg.msg_type;
                res_next.out_arg_one = offer_msg.arg_one;
                res_next.out_arg_two = offer_msg.arg_two;
            end
            else if (cmd.op == mfq_pkg::OP_GET_TAKE)
            begin
                res_next.delivered   = 1'b1;
                res_next.out_type    = rd_reg.msg_type;
                res_next.out_arg_one = rd_reg.arg_one;
                res_next.out_arg_two = rd_reg.arg_two;
            end
            else if (cmd.op == mfq_pkg::OP_ABORT)
            begin
                res_next.status = waiting_reg ? mfq_pkg::ST_ABORTED : mfq_pkg::ST_OK;
            end
        end
    end

    always_comb
    begin
        out_next              = res_reg;
        out_next.queued_count = 5'(count_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            item_reg <= cmd_item;
        end
        res_reg <= res_next;
        if (cmd.emit)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            rd_cnt_reg    <= '0;
            wr_cnt_reg    <= '0;
            abort_reg     <= 1'b1;
            waiting_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_abort)
            begin
                abort_reg <= 1'b0;
            end
            unique case (cmd.op)
                mfq_pkg::OP_DELIVER:
                begin
                    waiting_reg <= 1'b0;
                end
                mfq_pkg::OP_ENQUEUE:
                begin
                    count_reg <= count_reg + 1'b1;
                end
                mfq_pkg::OP_GET_TAKE:
                begin
                    head_reg  <= mfq_pkg::wrap_add(head_reg, mfq_pkg::CNT_W'(1));
                    count_reg <= count_reg - 1'b1;
                end
                mfq_pkg::OP_PARK:
                begin
                    waiting_reg <= 1'b1;
                end
                mfq_pkg::OP_FLUSH:
                begin
                    count_reg <= '0;
                end
                mfq_pkg::OP_ABORT:
                begin
                    abort_reg   <= 1'b1;
                    waiting_reg <= 1'b0;
                end
                mfq_pkg::OP_RM_START:
                begin
                    rd_cnt_reg <= '0;
                    wr_cnt_reg <= '0;
                end
                mfq_pkg::OP_RM_CHECK:
                begin
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                    if (!rm_match)
                    begin
                        wr_cnt_reg <= wr_cnt_reg + 1'b1;
                    end
                end
                mfq_pkg::OP_RM_END:
                begin
                    count_reg <= wr_cnt_reg;
                end
                default:
                begin
                end
            endcase
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.action        = item_reg.action;
    assign sts.wait_if_empty = item_reg.wait_if_empty;
    assign sts.aborted       = abort_reg;
    assign sts.waiting       = waiting_reg;
    assign sts.empty         = (count_reg == '0);
    assign sts.full          = (count_reg >= mfq_pkg::CNT_W'(mfq_pkg::QUEUE_DEPTH));
    assign sts.rm_done       = (rd_cnt_reg == count_reg);
    assign sts.out_free      = out_free;

    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_reg;

endmodule

/* sv/mfq_ctrl.sv */
// ----------------------------------------------------------------------------
// mfq_ctrl
// Sequencer: decodes one transaction and steps the datapath through it.
// ----------------------------------------------------------------------------
module mfq_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  mfq_pkg::dp_sts_t sts,
    output mfq_pkg::dp_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_GET_READ,
        S_RM_READ,
        S_RM_CHECK,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        cmd.op          = mfq_pkg::OP_NONE;
        cmd.res_status  = mfq_pkg::ST_OK;
        cmd.clear_abort = 1'b0;
        cmd.take_item   = 1'b0;
        cmd.emit        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd.take_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_RESP;
                priority if (sts.action == mfq_pkg::ACT_PUT ||
                             sts.action == mfq_pkg::ACT_START)
                begin
                    if (sts.action == mfq_pkg::ACT_PUT && sts.aborted)
                    begin
                        cmd.op         = mfq_pkg::OP_RES_STATUS;
                        cmd.res_status = mfq_pkg::ST_ABORTED;
                    end
                    else
                    begin
                        cmd.clear_abort = (sts.action == mfq_pkg::ACT_START);
                        priority if (sts.waiting)
                        begin
                            cmd.op = mfq_pkg::OP_DELIVER;
                        end
                        else if (sts.full)
                        begin
                            cmd.op         = mfq_pkg::OP_RES_STATUS;
                            cmd.res_status = mfq_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.op = mfq_pkg::OP_ENQUEUE;
                        end
                    end
                end
                else if (sts.action == mfq_pkg::ACT_GET)
                begin
                    priority if (sts.aborted)
                    begin
                        cmd.op         = mfq_pkg::OP_RES_STATUS;
                        cmd.res_status = mfq_pkg::ST_ABORTED;
                    end
                    else if (!sts.empty)
                    begin
                        cmd.op     = mfq_pkg::OP_GET_ISSUE;
                        state_next = S_GET_READ;
                    end
                    else if (sts.wait_if_empty && !sts.waiting)
                    begin
                        cmd.op     = mfq_pkg::OP_PARK;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.op         = mfq_pkg::OP_RES_STATUS;
                        cmd.res_status = mfq_pkg::ST_EMPTY;
                    end
                end
                else if (sts.action == mfq_pkg::ACT_REMOVE)
                begin
                    if (sts.aborted)
                    begin
                        cmd.op         = mfq_pkg::OP_RES_STATUS;
                        cmd.res_status = mfq_pkg::ST_ABORTED;
                    end
                    else
                    begin
                        cmd.op     = mfq_pkg::OP_RM_START;
                        state_next = S_RM_READ;
                    end
                end
                else if (sts.action == mfq_pkg::ACT_FLUSH)
                begin
                    cmd.op = mfq_pkg::OP_FLUSH;
                end
                else if (sts.action == mfq_pkg::ACT_ABORT)
                begin
                    cmd.op = mfq_pkg::OP_ABORT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_GET_READ:
            begin
                cmd.op     = mfq_pkg::OP_GET_TAKE;
                state_next = S_RESP;
            end
            S_RM_READ:
            begin
                if (sts.rm_done)
                begin
                    cmd.op     = mfq_pkg::OP_RM_END;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.op     = mfq_pkg::OP_RM_READ;
                    state_next = S_RM_CHECK;
                end
            end
            S_RM_CHECK:
            begin
                cmd.op     = mfq_pkg::OP_RM_CHECK;
                state_next = S_RM_READ;
            end
            S_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
